[design/mlrq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_pkg
// Widths, request and status codes, and level table update type for the
// multilevel ready queue.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int SLOT_W     = 5;
    localparam int LVL_W      = 2;
    localparam int NUM_SLOTS  = 1 << SLOT_W;
    localparam int NUM_LEVELS = 1 << LVL_W;

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_REM  = 2'd2,
        MODE_FIND = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_DUP  = 2'd2
    } t_status;

    typedef struct packed {
        logic              set_head;
        logic              set_tail;
        logic              set_ne;
        logic              clr_ne;
        logic [LVL_W-1:0]  lvl;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_lvl_upd;

endpackage
`default_nettype wire

[design/mlrq_lvl_tbl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_lvl_tbl
// Per-level head, tail and non-empty flags, with the highest-priority pick
// over the non-empty levels.
// ----------------------------------------------------------------------------
module mlrq_lvl_tbl import mlrq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [LVL_W-1:0]  i_sel,
    input  wire t_lvl_upd          i_upd,
    output logic      [SLOT_W-1:0] o_head,
    output logic      [SLOT_W-1:0] o_tail,
    output logic                   o_nonempty,
    output logic                   o_any,
    output logic      [LVL_W-1:0]  o_pick
);

    logic [SLOT_W-1:0]     r_head [NUM_LEVELS];
    logic [SLOT_W-1:0]     r_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_ne;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne <= '0;
        end else begin
            if (i_upd.set_ne) begin
                r_ne[i_upd.lvl] <= 1'b1;
            end else if (i_upd.clr_ne) begin
                r_ne[i_upd.lvl] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.set_head) begin
            r_head[i_upd.lvl] <= i_upd.head;
        end
        if (i_upd.set_tail) begin
            r_tail[i_upd.lvl] <= i_upd.tail;
        end
    end

    always_comb begin
        o_pick = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_ne[i]) begin
                o_pick = LVL_W'(i);
            end
        end
    end

    assign o_any      = |r_ne;
    assign o_head     = r_head[i_sel];
    assign o_tail     = r_tail[i_sel];
    assign o_nonempty = r_ne[i_sel];

endmodule
`default_nettype wire

[design/multilevel_ready_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_ready_queue_unit
// Ready queue with one FIFO of process slots per priority level. Links and
// slot levels live in two synchronous memories; requests run on an FSM.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   request  | i_valid / o_stall      | i_mode, i_slot, i_level
//   result   | o_valid / i_stall      | o_status, o_out_slot, o_out_level
//
// Enqueue and find end in S_LOOK, dequeue there or in S_HEAD. Remove ends
// in S_LOOK or S_HEAD, or walks the links ahead of the slot in S_WALK and
// ends there or in S_SPLICE; the single link read port walks a link per cycle.
// Synchronous reset empties all levels; no clearing pass is needed.
// A new request is taken once the FSM is idle and the result register is
// empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_unit import mlrq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [LVL_W-1:0]  i_level,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [1:0]        o_status,
    output logic      [SLOT_W-1:0] o_out_slot,
    output logic      [LVL_W-1:0]  o_out_level
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_WALK   = 5'b00100,
        S_SPLICE = 5'b01000,
        S_HEAD   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [LVL_W-1:0]     r_lv, n_lv;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [NUM_SLOTS-1:0] r_queued;

    logic [SLOT_W-1:0]    link_mem [NUM_SLOTS];
    logic [LVL_W-1:0]     lvl_mem  [NUM_SLOTS];
    logic [SLOT_W-1:0]    r_link_rd;
    logic [LVL_W-1:0]     r_lvl_rd;

    logic                 r_o_valid;
    t_status              r_o_status;
    logic [SLOT_W-1:0]    r_o_slot;
    logic [LVL_W-1:0]     r_o_level;

    logic                 accept;
    logic                 link_we;
    logic [SLOT_W-1:0]    link_wa, link_wd, link_ra;
    logic                 lvl_we;
    logic                 q_set, q_clr;
    logic [SLOT_W-1:0]    q_idx;
    logic                 fin;
    t_status              fin_st;
    logic [SLOT_W-1:0]    fin_slot;
    logic [LVL_W-1:0]     fin_lvl;

    t_lvl_upd             upd;
    logic [LVL_W-1:0]     tbl_sel;
    logic [SLOT_W-1:0]    tbl_head, tbl_tail;
    logic                 tbl_ne, tbl_any;
    logic [LVL_W-1:0]     tbl_pick;

    mlrq_lvl_tbl u_lvl_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sel      (tbl_sel),
        .i_upd      (upd),
        .o_head     (tbl_head),
        .o_tail     (tbl_tail),
        .o_nonempty (tbl_ne),
        .o_any      (tbl_any),
        .o_pick     (tbl_pick)
    );

    assign accept  = (r_state == S_IDLE) && i_valid && (!r_o_valid || !i_stall);
    assign o_stall = !((r_state == S_IDLE) && (!r_o_valid || !i_stall));
    assign tbl_sel = ((r_state == S_LOOK) && (r_mode == MODE_DEQ)) ? tbl_pick : r_lv;

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_lv     = r_lv;
        n_cur    = r_cur;
        upd      = '0;
        link_we  = 1'b0;
        link_wa  = r_cur;
        link_wd  = r_slot;
        link_ra  = r_slot;
        lvl_we   = 1'b0;
        q_set    = 1'b0;
        q_clr    = 1'b0;
        q_idx    = r_slot;
        fin      = 1'b0;
        fin_st   = ST_NONE;
        fin_slot = r_slot;
        fin_lvl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                case (r_mode)
                    MODE_ENQ: begin
                        fin = 1'b1;
                        if (r_queued[r_slot]) begin
                            fin_st  = ST_DUP;
                            fin_lvl = r_lvl_rd;
                        end else begin
                            if (tbl_ne) begin
                                link_we = 1'b1;
                                link_wa = tbl_tail;
                                link_wd = r_slot;
                            end else begin
                                upd.set_head = 1'b1;
                            end
                            upd.set_tail = 1'b1;
                            upd.set_ne   = 1'b1;
                            upd.lvl      = r_lv;
                            upd.head     = r_slot;
                            upd.tail     = r_slot;
                            q_set        = 1'b1;
                            lvl_we       = 1'b1;
                            fin_st       = ST_OK;
                            fin_lvl      = r_lv;
                        end
                    end
                    MODE_FIND: begin
                        fin = 1'b1;
                        if (r_queued[r_slot]) begin
                            fin_st  = ST_OK;
                            fin_lvl = r_lvl_rd;
                        end
                    end
                    MODE_DEQ: begin
                        if (tbl_any) begin
                            q_clr  = 1'b1;
                            q_idx  = tbl_head;
                            n_slot = tbl_head;
                            n_lv   = tbl_pick;
                            if (tbl_head == tbl_tail) begin
                                upd.clr_ne = 1'b1;
                                upd.lvl    = tbl_pick;
                                fin        = 1'b1;
                                fin_st     = ST_OK;
                                fin_slot   = tbl_head;
                                fin_lvl    = tbl_pick;
                            end else begin
                                link_ra = tbl_head;
                                n_state = S_HEAD;
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        if (!r_queued[r_slot] || (r_lvl_rd != r_lv) || !tbl_ne) begin
                            fin = 1'b1;
                        end else if (tbl_head == r_slot) begin
                            q_clr = 1'b1;
                            if (tbl_tail == r_slot) begin
                                upd.clr_ne = 1'b1;
                                upd.lvl    = r_lv;
                                fin        = 1'b1;
                                fin_st     = ST_OK;
                                fin_lvl    = r_lv;
                            end else begin
                                link_ra = r_slot;
                                n_state = S_HEAD;
                            end
                        end else if (tbl_head == tbl_tail) begin
                            fin = 1'b1;
                        end else begin
                            n_cur   = tbl_head;
                            link_ra = tbl_head;
                            n_state = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                if (r_link_rd == r_slot) begin
                    if (tbl_tail == r_slot) begin
                        upd.set_tail = 1'b1;
                        upd.lvl      = r_lv;
                        upd.tail     = r_cur;
                        q_clr        = 1'b1;
                        fin          = 1'b1;
                        fin_st       = ST_OK;
                        fin_lvl      = r_lv;
                    end else begin
                        link_ra = r_slot;
                        n_state = S_SPLICE;
                    end
                end else begin
                    n_cur = r_link_rd;
                    if (r_link_rd == tbl_tail) begin
                        fin = 1'b1;
                    end else begin
                        link_ra = r_link_rd;
                    end
                end
            end
            S_SPLICE: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_link_rd;
                q_clr   = 1'b1;
                fin     = 1'b1;
                fin_st  = ST_OK;
                fin_lvl = r_lv;
            end
            S_HEAD: begin
                upd.set_head = 1'b1;
                upd.lvl      = r_lv;
                upd.head     = r_link_rd;
                fin          = 1'b1;
                fin_st       = ST_OK;
                fin_lvl      = r_lv;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_queued  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (q_set) begin
                r_queued[q_idx] <= 1'b1;
            end else if (q_clr) begin
                r_queued[q_idx] <= 1'b0;
            end
            if (fin) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_slot <= i_slot;
            r_lv   <= i_level;
        end else begin
            r_slot <= n_slot;
            r_lv   <= n_lv;
        end
        r_cur <= n_cur;
        if (fin) begin
            r_o_status <= fin_st;
            r_o_slot   <= fin_slot;
            r_o_level  <= fin_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[r_slot] <= r_lv;
        end
        if (accept) begin
            r_lvl_rd <= lvl_mem[i_slot];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_out_slot  = r_o_slot;
    assign o_out_level = r_o_level;

    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_o_valid)
        else $error("result register occupied while a request is in flight");

    a_enq_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_o_valid) && (r_o_status == ST_OK) && (r_mode == MODE_ENQ))
        |-> r_queued[r_o_slot])
        else $error("enqueued slot not marked queued");

    a_pop_unqueued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_o_valid) && (r_o_status == ST_OK)
            && ((r_mode == MODE_DEQ) || (r_mode == MODE_REM)))
        |-> !r_queued[r_o_slot])
        else $error("popped or removed slot still marked queued");

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel ready queue. A short table of
// enqueue, dequeue, remove and find requests covers the empty, duplicate,
// head, middle and tail cases. Mostly well-formed random traffic follows,
// biased in turns toward filling and draining the levels. Each result is
// compared against a local model of the per-level FIFOs or the table row's
// expected result. Sender and receiver idle at random, bar the third phase.
// ----------------------------------------------------------------------------
module tb_top;
    import mlrq_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_PHASE  = 225;

    typedef struct packed {
        logic [1:0]        st;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  lvl;
    } t_result;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  lvl;
        logic              chk;
        t_result           want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [1:0]        i_mode = '0;
    logic [SLOT_W-1:0] i_slot = '0;
    logic [LVL_W-1:0]  i_level = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [SLOT_W-1:0] o_out_slot;
    logic [LVL_W-1:0]  o_out_level;

    int snd_idle = 29;
    int rcv_idle = 65;
    int mismatches = 0;
    int quiet = 0;

    t_result pending_res[$];

    logic [SLOT_W-1:0] rq_head [NUM_LEVELS] = '{default: '0};
    logic [SLOT_W-1:0] rq_tail [NUM_LEVELS] = '{default: '0};
    logic              rq_ne   [NUM_LEVELS] = '{default: 1'b0};
    logic [SLOT_W-1:0] rq_link [NUM_SLOTS]  = '{default: '0};
    logic              rq_on   [NUM_SLOTS]  = '{default: 1'b0};
    logic [LVL_W-1:0]  rq_lvl  [NUM_SLOTS]  = '{default: '0};

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{MODE_DEQ,  5'd31, 2'd3, 1'b1, '{ST_NONE, 5'd31, 2'd0}},
        '{MODE_FIND, 5'd0,  2'd0, 1'b1, '{ST_NONE, 5'd0,  2'd0}},
        '{MODE_REM,  5'd31, 2'd3, 1'b1, '{ST_NONE, 5'd31, 2'd0}},
        '{MODE_ENQ,  5'd0,  2'd0, 1'b1, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_ENQ,  5'd31, 2'd3, 1'b1, '{ST_OK,   5'd31, 2'd3}},
        '{MODE_ENQ,  5'd0,  2'd2, 1'b1, '{ST_DUP,  5'd0,  2'd0}},
        '{MODE_FIND, 5'd31, 2'd1, 1'b1, '{ST_OK,   5'd31, 2'd3}},
        '{MODE_ENQ,  5'd5,  2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_ENQ,  5'd10, 2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_ENQ,  5'd21, 2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_REM,  5'd10, 2'd2, 1'b1, '{ST_NONE, 5'd10, 2'd0}},
        '{MODE_REM,  5'd10, 2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_REM,  5'd21, 2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_REM,  5'd31, 2'd3, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_DEQ,  5'd7,  2'd0, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_DEQ,  5'd0,  2'd2, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_DEQ,  5'd31, 2'd3, 1'b1, '{ST_NONE, 5'd31, 2'd0}},
        '{MODE_ENQ,  5'd3,  2'd1, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_ENQ,  5'd4,  2'd1, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_REM,  5'd3,  2'd1, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_FIND, 5'd3,  2'd2, 1'b1, '{ST_NONE, 5'd3,  2'd0}},
        '{MODE_ENQ,  5'd3,  2'd1, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_DEQ,  5'd14, 2'd1, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_DEQ,  5'd27, 2'd2, 1'b0, '{ST_OK,   5'd0,  2'd0}},
        '{MODE_REM,  5'd4,  2'd0, 1'b1, '{ST_NONE, 5'd4,  2'd0}}
    };

    multilevel_ready_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_slot      (i_slot),
        .i_level     (i_level),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_out_slot  (o_out_slot),
        .o_out_level (o_out_level)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result ready_queue_step(t_mode m, logic [SLOT_W-1:0] s,
                                                 logic [LVL_W-1:0] l);
        t_result           r;
        logic [SLOT_W-1:0] h;
        logic [SLOT_W-1:0] cur;
        r = '{ST_NONE, s, '0};
        case (m)
            MODE_ENQ: begin
                if (rq_on[s]) begin
                    r = '{ST_DUP, s, rq_lvl[s]};
                end else begin
                    if (rq_ne[l]) rq_link[rq_tail[l]] = s;
                    else          rq_head[l] = s;
                    rq_tail[l] = s;
                    rq_ne[l]   = 1'b1;
                    rq_on[s]   = 1'b1;
                    rq_lvl[s]  = l;
                    r = '{ST_OK, s, l};
                end
            end
            MODE_DEQ: begin
                for (int i = 0; i < NUM_LEVELS; i++) begin
                    if (rq_ne[i]) begin
                        h = rq_head[i];
                        if (h == rq_tail[i]) rq_ne[i] = 1'b0;
                        else                 rq_head[i] = rq_link[h];
                        rq_on[h] = 1'b0;
                        r = '{ST_OK, h, LVL_W'(i)};
                        break;
                    end
                end
            end
            MODE_REM: begin
                if (rq_on[s] && rq_lvl[s] == l && rq_ne[l]) begin
                    if (rq_head[l] == s) begin
                        if (rq_tail[l] == s) rq_ne[l] = 1'b0;
                        else                 rq_head[l] = rq_link[s];
                        rq_on[s] = 1'b0;
                        r = '{ST_OK, s, l};
                    end else begin
                        cur = rq_head[l];
                        for (int n = 0; n < NUM_SLOTS; n++) begin
                            if (cur == rq_tail[l]) break;
                            if (rq_link[cur] == s) begin
                                if (rq_tail[l] == s) rq_tail[l] = cur;
                                else                 rq_link[cur] = rq_link[s];
                                rq_on[s] = 1'b0;
                                r = '{ST_OK, s, l};
                                break;
                            end
                            cur = rq_link[cur];
                        end
                    end
                end
            end
            default: begin
                if (rq_on[s]) r = '{ST_OK, s, rq_lvl[s]};
            end
        endcase
        return r;
    endfunction

    task automatic send_req(input t_mode m, input logic [SLOT_W-1:0] s,
                            input logic [LVL_W-1:0] l, input logic chk,
                            input t_result want);
        t_result got;
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= m;
        i_slot  <= s;
        i_level <= l;
        do @(posedge i_clk); while (o_stall);
        got = ready_queue_step(m, s, l);
        pending_res.push_back(chk ? want : got);
    endtask

    task automatic wait_queue_empty();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_res.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rcv_idle);
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d level %0d",
                         $time, o_status, o_out_slot, o_out_level);
                mismatches <= mismatches + 1;
            end else begin
                exp_res = pending_res.pop_front();
                if (exp_res.st != o_status || exp_res.slot != o_out_slot ||
                    exp_res.lvl != o_out_level) begin
                    $display("%0t: expected status %0d slot %0d level %0d, actual %0d %0d %0d",
                             $time, exp_res.st, exp_res.slot, exp_res.lvl,
                             o_status, o_out_slot, o_out_level);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_mode             m;
        logic [SLOT_W-1:0] s;
        logic [LVL_W-1:0]  l;
        int                pick;
        logic              fill;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            send_req(t_mode'(dir_tab[k].mode), dir_tab[k].slot, dir_tab[k].lvl,
                     dir_tab[k].chk, dir_tab[k].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_queue_empty();
            snd_idle <= (ph == 0) ? 29 : (ph == 1) ? 65 : 0;
            rcv_idle <= (ph == 0) ? 65 : (ph == 1) ? 29 : 0;
            for (int k = 0; k < RAND_PHASE; k++) begin
                if (k == RAND_PHASE / 2) wait_queue_empty();
                fill = ((k / 40) % 2) == 0;
                pick = $urandom_range(0, 99);
                s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                l = LVL_W'($urandom_range(0, NUM_LEVELS - 1));
                if (pick < (fill ? 55 : 25)) begin
                    m = MODE_ENQ;
                    if ($urandom_range(0, 99) < 85) begin
                        repeat (8) if (rq_on[s]) s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                    end
                end else if (pick < (fill ? 70 : 60)) begin
                    m = MODE_DEQ;
                end else if (pick < 85) begin
                    m = MODE_REM;
                    if ($urandom_range(0, 99) < 80) begin
                        repeat (8) if (!rq_on[s]) s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                        if (rq_on[s]) l = rq_lvl[s];
                    end
                end else begin
                    m = MODE_FIND;
                end
                send_req(m, s, l, 1'b0, '0);
            end
        end

        wait_queue_empty();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
design/mlrq_pkg.sv
design/mlrq_lvl_tbl.sv
design/multilevel_ready_queue_unit.sv
test/tb_top.sv
